// ===== design/line_upper_envelope_counter_assert.svh =====
// Assertion macros for the line upper envelope counter.
// Used by the top level; expects clk_i and rst_ni in the including scope.
`ifndef LINE_UPPER_ENVELOPE_COUNTER_ASSERT_SVH
`define LINE_UPPER_ENVELOPE_COUNTER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LUEC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("luec assertion failed");

// Next-cycle implication, checked outside reset.
`define LUEC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("luec assertion failed");

`endif

// ===== design/luec_pkg.sv =====
// Shared types, constants and functions of the line upper envelope counter.
// No dependencies; imported by the interfaces and all modules.
package luec_pkg;

  localparam int unsigned MAX_LINES_DEF = 1024;
  localparam int unsigned B_W   = 32;
  localparam int unsigned A_W   = 31;
  localparam int unsigned CNT_W = 11;
  localparam int unsigned PROD_W = B_W + A_W;

  typedef struct packed {
    logic signed [B_W-1:0] b;
    logic [A_W-1:0]        a;
  } line_t;

  typedef struct packed {
    logic  valid;
    line_t line;
  } cell_t;

  typedef struct packed {
    line_t line;
    logic  bad;
  } stack_t;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

  // True when x is placed strictly ahead of y: larger intercept, then larger slope.
  function automatic logic goes_before(line_t x, line_t y);
    if (x.b != y.b) begin
      return x.b > y.b;
    end
    return x.a > y.a;
  endfunction

  function automatic logic same_line(line_t x, line_t y);
    return (x.b == y.b) && (x.a == y.a);
  endfunction

endpackage

// ===== design/luec_in_if.sv =====
// Request channel carrying one line per request.
// Depends on luec_pkg.
interface luec_in_if import luec_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic signed [B_W-1:0] intercept;
  logic [A_W-1:0]        slope;
  logic                  last;

  modport source (output valid, output intercept, output slope, output last, input ready);
  modport sink (input valid, input intercept, input slope, input last, output ready);
endinterface

// ===== design/luec_out_if.sv =====
// Result channel carrying the envelope count and overflow flag.
// Depends on luec_pkg.
interface luec_out_if import luec_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] visible_count;
  logic             overflow;

  modport source (output valid, output visible_count, output overflow, input ready);
  modport sink (input valid, input visible_count, input overflow, output ready);
endinterface

// ===== design/luec_cell.sv =====
// One cell of the insertion-sort chain: holds one line in sorted position.
// Depends on luec_pkg.
module luec_cell import luec_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  line_t      new_i,
  input  cell_t      left_i,
  input  logic       ins_left_i,
  input  cell_t      right_i,
  output cell_t      cell_o,
  output logic       ins_o
);

  logic  valid_q, valid_d;
  line_t line_q, line_d;

  // The new line belongs here or earlier when this cell is empty or it sorts ahead.
  assign ins_o  = !valid_q || goes_before(new_i, line_q);
  assign cell_o = '{valid: valid_q, line: line_q};

  always_comb begin
    valid_d = valid_q;
    line_d  = line_q;
    if (ctrl_i.shift) begin
      valid_d = right_i.valid;
      line_d  = right_i.line;
    end else if (ctrl_i.load) begin
      if (ins_left_i) begin
        valid_d = left_i.valid;
        line_d  = left_i.line;
      end else if (ins_o) begin
        valid_d = 1'b1;
        line_d  = new_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    line_q <= line_d;
  end

endmodule

// ===== design/luec_hull.sv =====
// Envelope builder: drains the sorted chain and runs the monotone stack.
// Depends on luec_pkg.
module luec_hull import luec_pkg::*; #(
  parameter int unsigned MaxLines = MAX_LINES_DEF,
  localparam int unsigned DW = $clog2(MaxLines + 1),
  localparam int unsigned AW = $clog2(MaxLines)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          out_free_i,
  input  cell_t         head_i,
  input  cell_t         next_i,
  output logic          shift_o,
  output logic          done_o,
  output logic [DW-1:0] count_o
);

  localparam logic [1:0] H_IDLE  = 2'd0;
  localparam logic [1:0] H_FETCH = 2'd1;
  localparam logic [1:0] H_MUL   = 2'd2;
  localparam logic [1:0] H_CMP   = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [DW-1:0]     depth_q, depth_d;
  logic [DW-1:0]     cnt_q, cnt_d;
  stack_t            top_q, top_d, sub_q, sub_d, new_q, new_d;
  line_t             prev_q, prev_d;
  logic              prev_v_q, prev_v_d;
  logic [A_W-1:0]    best_q, best_d;
  logic              best_v_q, best_v_d;
  logic [PROD_W-1:0] lhs_q, rhs_q;
  stack_t            mem [MaxLines];
  stack_t            rd_q;
  logic              mem_we;
  logic [AW-1:0]     mem_wa;
  logic [DW-1:0]     rd_addr;
  logic              head_bad;
  stack_t            head_e;
  logic [B_W-1:0]    db_l, db_r;
  logic [A_W-1:0]    da_l, da_r;

  assign head_bad = (next_i.valid && same_line(head_i.line, next_i.line)) ||
                    (prev_v_q && same_line(prev_q, head_i.line));
  assign head_e   = '{line: head_i.line, bad: head_bad};
  assign rd_addr  = depth_q - DW'(3);
  assign mem_wa   = AW'(depth_q - DW'(2));
  assign count_o  = cnt_q;

  // Intercepts are non-increasing and slopes increasing from the bottom of the stack to its top.
  assign db_l = B_W'(top_q.line.b - new_q.line.b);
  assign da_l = top_q.line.a - sub_q.line.a;
  assign db_r = B_W'(sub_q.line.b - top_q.line.b);
  assign da_r = new_q.line.a - top_q.line.a;

  always_comb begin
    state_d  = state_q;
    depth_d  = depth_q;
    cnt_d    = cnt_q;
    top_d    = top_q;
    sub_d    = sub_q;
    new_d    = new_q;
    prev_d   = prev_q;
    prev_v_d = prev_v_q;
    best_d   = best_q;
    best_v_d = best_v_q;
    mem_we   = 1'b0;
    shift_o  = 1'b0;
    done_o   = 1'b0;
    case (state_q)
      H_IDLE: begin
        if (start_i) begin
          state_d  = H_FETCH;
          depth_d  = '0;
          cnt_d    = '0;
          prev_v_d = 1'b0;
          best_v_d = 1'b0;
        end
      end
      H_FETCH: begin
        if (!head_i.valid) begin
          if (out_free_i) begin
            done_o  = 1'b1;
            state_d = H_IDLE;
          end
        end else begin
          shift_o  = 1'b1;
          prev_d   = head_i.line;
          prev_v_d = 1'b1;
          if (!best_v_q || head_i.line.a > best_q) begin
            best_d   = head_i.line.a;
            best_v_d = 1'b1;
            if (depth_q >= DW'(2)) begin
              new_d   = head_e;
              state_d = H_MUL;
            end else begin
              top_d   = head_e;
              sub_d   = top_q;
              depth_d = depth_q + DW'(1);
              cnt_d   = cnt_q + DW'(!head_bad);
            end
          end
        end
      end
      H_MUL: begin
        state_d = H_CMP;
      end
      H_CMP: begin
        if (lhs_q <= rhs_q) begin
          if (depth_q > DW'(2)) begin
            // Pop and test the new line against the next pair down.
            top_d   = sub_q;
            sub_d   = rd_q;
            depth_d = depth_q - DW'(1);
            cnt_d   = cnt_q - DW'(!top_q.bad);
            state_d = H_MUL;
          end else begin
            // Pop down to one entry, then push the new line.
            top_d   = new_q;
            cnt_d   = cnt_q - DW'(!top_q.bad) + DW'(!new_q.bad);
            state_d = H_FETCH;
          end
        end else begin
          mem_we  = 1'b1;
          sub_d   = top_q;
          top_d   = new_q;
          depth_d = depth_q + DW'(1);
          cnt_d   = cnt_q + DW'(!new_q.bad);
          state_d = H_FETCH;
        end
      end
      default: begin
        state_d = H_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= H_IDLE;
      depth_q  <= '0;
      cnt_q    <= '0;
      prev_v_q <= 1'b0;
      best_v_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      depth_q  <= depth_d;
      cnt_q    <= cnt_d;
      prev_v_q <= prev_v_d;
      best_v_q <= best_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q  <= top_d;
    sub_q  <= sub_d;
    new_q  <= new_d;
    prev_q <= prev_d;
    best_q <= best_d;
    lhs_q  <= PROD_W'(db_l) * PROD_W'(da_l);
    rhs_q  <= PROD_W'(db_r) * PROD_W'(da_r);
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= sub_q;
    end
    rd_q <= mem[rd_addr[AW-1:0]];
  end

endmodule

// ===== design/line_upper_envelope_counter.sv =====
// Line upper envelope counter. Lines enter one per cycle, except during an envelope pass,
// and are insertion-sorted into a chain of MaxLines cells (intercept descending, then slope
// descending); a line that finds the chain full is dropped and flagged. The request marked
// last starts the envelope pass: the chain shifts its lines out toward the head one per
// cycle while the stack is not busy testing, runs of identical lines are marked bad, lines
// that do not raise the running maximum slope are skipped, and the rest feed a monotone
// stack whose pop test is an exact comparison of two 32x31-bit products. Each stack test
// runs as a multiply step and then a compare step; no requests are taken during the pass.
// The result (count of non-bad envelope lines, saturated to 11 bits, and the overflow flag)
// sits in an output register, and the next set may load while it waits.
// Depends on luec_pkg, luec_in_if, luec_out_if, luec_cell and luec_hull.
`include "line_upper_envelope_counter_assert.svh"

module line_upper_envelope_counter import luec_pkg::*; #(
  parameter int unsigned MaxLines = MAX_LINES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  luec_in_if.sink     in_i,
  luec_out_if.source  out_o
);

  localparam int unsigned DW = $clog2(MaxLines + 1);

  cell_t            cells [MaxLines];
  logic             ins [MaxLines];
  logic [MaxLines-1:0] cell_valid;
  cell_ctrl_t       ctrl;
  line_t            new_line;
  logic             accept, full;
  logic             busy_q, dropped_q;
  logic             out_valid_q;
  logic [CNT_W-1:0] count_q;
  logic             ovf_q;
  logic             shift, hull_done;
  logic [DW-1:0]    hull_cnt;
  logic [CNT_W-1:0] sat_cnt;

  // Requests are taken only while no envelope pass runs.
  assign in_i.ready = !busy_q;
  assign accept     = in_i.valid && in_i.ready;
  assign full       = cells[MaxLines-1].valid;
  assign new_line   = '{b: in_i.intercept, a: in_i.slope};
  assign ctrl       = '{load: accept && !full, shift: shift};

  for (genvar i = 0; i < MaxLines; i++) begin : g_cell
    cell_t left, right;
    logic  ins_left;
    if (i == 0) begin : g_first
      assign left     = '0;
      assign ins_left = 1'b0;
    end else begin : g_mid
      assign left     = cells[i-1];
      assign ins_left = ins[i-1];
    end
    if (i == MaxLines - 1) begin : g_last
      assign right = '0;
    end else begin : g_inner
      assign right = cells[i+1];
    end
    luec_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .new_i      (new_line),
      .left_i     (left),
      .ins_left_i (ins_left),
      .right_i    (right),
      .cell_o     (cells[i]),
      .ins_o      (ins[i])
    );
    assign cell_valid[i] = cells[i].valid;
  end

  // The hull unit only finishes once the output register can take the new result.
  luec_hull #(.MaxLines(MaxLines)) u_hull (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept && in_i.last),
    .out_free_i (!out_valid_q || out_o.ready),
    .head_i     (cells[0]),
    .next_i     (cells[1]),
    .shift_o    (shift),
    .done_o     (hull_done),
    .count_o    (hull_cnt)
  );

  // Counts beyond the field's range saturate.
  assign sat_cnt = (32'(hull_cnt) > 32'd2047) ? '1 : CNT_W'(hull_cnt);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      dropped_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept && in_i.last) begin
        busy_q <= 1'b1;
      end else if (hull_done) begin
        busy_q <= 1'b0;
      end
      if (hull_done) begin
        dropped_q <= 1'b0;
      end else if (accept && full) begin
        dropped_q <= 1'b1;
      end
      if (hull_done) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (hull_done) begin
      count_q <= sat_cnt;
      ovf_q   <= dropped_q;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.visible_count = count_q;
  assign out_o.overflow      = ovf_q;

  // The pass ends only while one is running.
  `LUEC_ASSERT_NOW(a_done_in_pass, hull_done, busy_q)
  // Accepting the last line always starts a pass.
  `LUEC_ASSERT_NEXT(a_last_starts, accept && in_i.last, busy_q)
  // While loading, occupied cells form a prefix of the chain.
  `LUEC_ASSERT_NOW(a_prefix, !busy_q, (cell_valid & (cell_valid + 1'b1)) == '0)
  // A finished pass leaves the chain empty.
  `LUEC_ASSERT_NOW(a_drained, hull_done, !cells[0].valid)

endmodule
